/* rtl/bsfr_pkg.sv */
package bsfr_pkg;

  // Line control bytes
  localparam logic [7:0] BYTE_END  = 8'hC0;
  localparam logic [7:0] BYTE_ESC  = 8'hDB;
  localparam logic [7:0] BYTE_TEND = 8'hDC;
  localparam logic [7:0] BYTE_TESC = 8'hDD;

  // Address field marking
  localparam logic [7:0] ADDR_FLAG = 8'h80;
  localparam logic [6:0] ADDR_MASK = 7'h7F;

  // Reflected CRC-8
  localparam logic [7:0] CRC_START = 8'hDE;
  localparam logic [7:0] CRC_POLY  = 8'h18;

  // Receive phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_FIRST = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CRC   = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_START = 2'd1;
  localparam logic [1:0] ST_BAD_ESC  = 2'd2;
  localparam logic [1:0] ST_CRC_ERR  = 2'd3;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int TDATA_W = 48;

  // Fold one byte into the CRC, LSB first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] b_in);
    logic [7:0] c;
    logic [7:0] b;
    c = crc_in;
    b = b_in;
    for (int i = 0; i < 8; i++) begin
      if ((b[0] ^ c[0]) == 1'b1) begin
        c = ((c ^ CRC_POLY) >> 1) | 8'h80;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    return c;
  endfunction

  localparam logic [7:0] CRC_OPEN = crc_feed(CRC_START, BYTE_END);

endpackage

/* rtl/byte_stuffed_frame_receiver_unit.sv */
// Channel  Dir  Width  Contents
// s_*      in   8      tdata: line_byte
// m_*      out  48     tdata: payload_byte, payload_index, has_address, address,
//                      command_code, length, status, zero pad; tuser: kind;
//                      tlast: last
//
// One line byte per cycle; each accepted byte is decoded in the cycle it is
// taken and its result (if any) shows on m_* the next cycle.
// The only limit is the single output register: s_tready drops while a result
// sits unaccepted on m_*.
// rst is synchronous, active high; it returns the receiver to idle, waiting
// for a frame-end byte, and empties the output register.
module byte_stuffed_frame_receiver_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] line_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] payload_byte, [15:8] payload_index, [16] has_address,
  // [23:17] address, [31:24] command_code, [39:32] length, [41:40] status
  output logic [bsfr_pkg::TDATA_W-1:0]   m_tdata,
  output logic                           m_tuser,   // [0] kind
  output logic                           m_tlast    // last
);
  import bsfr_pkg::*;

  // Frame state
  logic [2:0] phase, phase_next;
  logic       escape_pending, escape_pending_next;
  logic [7:0] running_crc, running_crc_next;
  logic [6:0] frame_address, frame_address_next;
  logic       address_seen, address_seen_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_received, bytes_received_next;

  // Result of the current byte
  logic       res_valid;
  logic       res_kind;
  logic [7:0] res_byte;
  logic [7:0] res_index;
  logic [1:0] res_status;
  logic       res_with_frame;
  logic       res_last;

  logic [7:0] b;
  logic [7:0] d;
  logic       d_valid;
  logic       s_fire;

  assign b        = s_tdata;
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  // Decode one line byte
  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    running_crc_next    = running_crc;
    frame_address_next  = frame_address;
    address_seen_next   = address_seen;
    frame_command_next  = frame_command;
    frame_length_next   = frame_length;
    bytes_received_next = bytes_received;
    res_valid      = 1'b0;
    res_kind       = KIND_END;
    res_byte       = 8'd0;
    res_index      = 8'd0;
    res_status     = ST_OK;
    res_with_frame = 1'b0;
    res_last       = 1'b0;
    d              = b;
    d_valid        = 1'b0;

    if (phase inside {PH_FIRST, PH_CMD, PH_LEN, PH_DATA, PH_CRC}) begin
      // unescape
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (b == BYTE_TEND) begin
          d       = BYTE_END;
          d_valid = 1'b1;
        end else if (b == BYTE_TESC) begin
          d       = BYTE_ESC;
          d_valid = 1'b1;
        end else begin
          res_valid      = 1'b1;
          res_kind       = KIND_END;
          res_status     = ST_BAD_ESC;
          res_with_frame = 1'b1;
          res_last       = 1'b1;
          phase_next     = PH_IDLE;
        end
      end else if (b == BYTE_ESC) begin
        escape_pending_next = 1'b1;
      end else begin
        d_valid = 1'b1;
      end

      // frame fields
      if (d_valid) begin
        case (phase)
          PH_FIRST: begin
            if ((d & ADDR_FLAG) != 8'd0) begin
              frame_address_next = d[6:0] & ADDR_MASK;
              address_seen_next  = 1'b1;
              running_crc_next   = crc_feed(running_crc, {1'b0, d[6:0]});
              phase_next         = PH_CMD;
            end else begin
              frame_command_next = d;
              running_crc_next   = crc_feed(running_crc, d);
              phase_next         = PH_LEN;
            end
          end
          PH_CMD: begin
            frame_command_next = d;
            running_crc_next   = crc_feed(running_crc, d);
            phase_next         = PH_LEN;
          end
          PH_LEN: begin
            frame_length_next   = d;
            bytes_received_next = 8'd0;
            running_crc_next    = crc_feed(running_crc, d);
            phase_next          = (d == 8'd0) ? PH_CRC : PH_DATA;
          end
          PH_DATA: begin
            res_valid           = 1'b1;
            res_kind            = KIND_DATA;
            res_byte            = d;
            res_index           = bytes_received;
            res_with_frame      = 1'b1;
            running_crc_next    = crc_feed(running_crc, d);
            bytes_received_next = bytes_received + 8'd1;
            if (bytes_received_next == frame_length) begin
              phase_next = PH_CRC;
            end
          end
          default: begin
            // CRC byte closes the frame
            res_valid      = 1'b1;
            res_kind       = KIND_END;
            res_status     = (d == running_crc) ? ST_OK : ST_CRC_ERR;
            res_with_frame = 1'b1;
            res_last       = 1'b1;
            phase_next     = PH_IDLE;
          end
        endcase
      end
    end else begin
      // idle, and unused phase codes
      escape_pending_next = 1'b0;
      if (b != BYTE_END) begin
        phase_next = PH_IDLE;
        res_valid  = 1'b1;
        res_kind   = KIND_END;
        res_status = ST_NO_START;
        res_last   = 1'b1;
      end else begin
        frame_address_next  = 7'd0;
        address_seen_next   = 1'b0;
        frame_command_next  = 8'd0;
        frame_length_next   = 8'd0;
        bytes_received_next = 8'd0;
        running_crc_next    = CRC_OPEN;
        phase_next          = PH_FIRST;
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      escape_pending <= 1'b0;
      running_crc    <= CRC_START;
      frame_address  <= 7'd0;
      address_seen   <= 1'b0;
      frame_command  <= 8'd0;
      frame_length   <= 8'd0;
      bytes_received <= 8'd0;
    end else if (s_fire) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      running_crc    <= running_crc_next;
      frame_address  <= frame_address_next;
      address_seen   <= address_seen_next;
      frame_command  <= frame_command_next;
      frame_length   <= frame_length_next;
      bytes_received <= bytes_received_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= {6'd0,
                  res_status,
                  res_with_frame ? frame_length  : 8'd0,
                  res_with_frame ? frame_command : 8'd0,
                  res_with_frame ? frame_address : 7'd0,
                  res_with_frame ? address_seen  : 1'b0,
                  res_index,
                  res_byte};
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

  // Data results never end a frame; reports always do
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == m_tlast))
    else $error("kind and last disagree");

  // An error status only appears on a frame-ending report
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[41:40] != ST_OK) |-> (m_tlast && m_tdata[15:0] == 16'd0))
    else $error("error status on a data result");

  // Data phase always has bytes still to come
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_received < frame_length))
    else $error("data phase with no bytes left");

  // An escape can only be pending inside a frame
  assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> (phase != PH_IDLE))
    else $error("escape pending while idle");

endmodule

/* sim/byte_stuffed_frame_receiver_unit_test.sv */
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver_unit_test;
  import bsfr_pkg::*;

  // One decoded result as the receiver should give it
  typedef struct {
    logic       kind;
    logic [7:0] pbyte;
    logic [7:0] pidx;
    logic       has_addr;
    logic [6:0] addr;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [1:0] status;
    logic       is_last;
  } rx_result_t;

  // Reflected CRC-8, one byte folded in LSB first
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = crc[0] ^ data[0];
      crc = fb ? {1'b1, crc[7:1] ^ 7'h0C} : {1'b0, crc[7:1]};
      data = data >> 1;
    end
    return crc;
  endfunction

  class frame_scoreboard;
    // Decoder state mirrored from the line side
    logic [2:0] rx_phase = PH_IDLE;
    logic       esc_seen = 1'b0;
    logic [7:0] crc_acc = CRC_START;
    logic [6:0] frm_addr = '0;
    logic       frm_has_addr = 1'b0;
    logic [7:0] frm_cmd = '0;
    logic [7:0] frm_len = '0;
    logic [7:0] data_count = '0;

    rx_result_t expected_results[$];
    int error_count = 0;

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
      error_count++;
    endtask

    function void push_result(logic kind, logic [7:0] pbyte, logic [7:0] pidx,
                              logic [1:0] status, logic is_last, bit with_frame);
      rx_result_t r;
      r.kind     = kind;
      r.pbyte    = pbyte;
      r.pidx     = pidx;
      r.has_addr = with_frame ? frm_has_addr : 1'b0;
      r.addr     = with_frame ? frm_addr : 7'd0;
      r.cmd      = with_frame ? frm_cmd : 8'd0;
      r.len      = with_frame ? frm_len : 8'd0;
      r.status   = status;
      r.is_last  = is_last;
      expected_results.push_back(r);
    endfunction

    // Predict the effect of one accepted line byte
    function void note_line_byte(logic [7:0] b);
      logic [7:0] v;
      v = b;
      if (rx_phase == PH_IDLE || rx_phase > PH_CRC) begin
        esc_seen = 1'b0;
        if (v != BYTE_END) begin
          rx_phase = PH_IDLE;
          push_result(KIND_END, 8'd0, 8'd0, ST_NO_START, 1'b1, 1'b0);
          return;
        end
        frm_addr     = '0;
        frm_has_addr = 1'b0;
        frm_cmd      = '0;
        frm_len      = '0;
        data_count   = '0;
        crc_acc      = crc8_update(CRC_START, BYTE_END);
        rx_phase     = PH_FIRST;
        return;
      end

      // Undo escaping
      if (esc_seen) begin
        esc_seen = 1'b0;
        if (v == BYTE_TEND) begin
          v = BYTE_END;
        end else if (v == BYTE_TESC) begin
          v = BYTE_ESC;
        end else begin
          push_result(KIND_END, 8'd0, 8'd0, ST_BAD_ESC, 1'b1, 1'b1);
          rx_phase = PH_IDLE;
          return;
        end
      end else if (v == BYTE_ESC) begin
        esc_seen = 1'b1;
        return;
      end

      case (rx_phase)
        PH_FIRST: begin
          if ((v & ADDR_FLAG) != 8'd0) begin
            frm_addr     = v[6:0];
            frm_has_addr = 1'b1;
            crc_acc      = crc8_update(crc_acc, {1'b0, v[6:0]});
            rx_phase     = PH_CMD;
          end else begin
            frm_cmd  = v;
            crc_acc  = crc8_update(crc_acc, v);
            rx_phase = PH_LEN;
          end
        end
        PH_CMD: begin
          frm_cmd  = v;
          crc_acc  = crc8_update(crc_acc, v);
          rx_phase = PH_LEN;
        end
        PH_LEN: begin
          frm_len    = v;
          data_count = '0;
          crc_acc    = crc8_update(crc_acc, v);
          rx_phase   = (v == 8'd0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          push_result(KIND_DATA, v, data_count, ST_OK, 1'b0, 1'b1);
          crc_acc    = crc8_update(crc_acc, v);
          data_count = data_count + 8'd1;
          if (data_count == frm_len) rx_phase = PH_CRC;
        end
        default: begin
          push_result(KIND_END, 8'd0, 8'd0, (v == crc_acc) ? ST_OK : ST_CRC_ERR,
                      1'b1, 1'b1);
          rx_phase = PH_IDLE;
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest expectation
    task check_result(logic [TDATA_W-1:0] td, logic tu, logic tl);
      rx_result_t w;
      if (expected_results.size() == 0) begin
        report("unexpected result tdata", 64'(td), 64'd0);
        return;
      end
      w = expected_results.pop_front();
      if (tu !== w.kind)          report("kind", 64'(tu), 64'(w.kind));
      if (td[7:0] !== w.pbyte)    report("payload_byte", 64'(td[7:0]), 64'(w.pbyte));
      if (td[15:8] !== w.pidx)    report("payload_index", 64'(td[15:8]), 64'(w.pidx));
      if (td[16] !== w.has_addr)  report("has_address", 64'(td[16]), 64'(w.has_addr));
      if (td[23:17] !== w.addr)   report("address", 64'(td[23:17]), 64'(w.addr));
      if (td[31:24] !== w.cmd)    report("command_code", 64'(td[31:24]), 64'(w.cmd));
      if (td[39:32] !== w.len)    report("length", 64'(td[39:32]), 64'(w.len));
      if (td[41:40] !== w.status) report("status", 64'(td[41:40]), 64'(w.status));
      if (td[47:42] !== 6'd0)     report("tdata pad", 64'(td[47:42]), 64'd0);
      if (tl !== w.is_last)       report("last", 64'(tl), 64'(w.is_last));
    endtask

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 950;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  frame_scoreboard sb;
  logic [7:0] line_bytes[$];
  logic [7:0] payload_bytes[$];
  int sent_count = 0;
  int cycle_count = 0;
  int raw_end_pct = 0;
  bit burst = 0;

  byte_stuffed_frame_receiver_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Transaction monitors on both sides
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      if (s_tvalid && s_tready) sb.note_line_byte(s_tdata);
    end
  end

  // Sink side: ready runs broken by stalls, mostly short
  initial begin
    int run_len;
    int stall;
    int r;
    @(negedge rst);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) stall = 0;
      else if (r < 85) stall = $urandom_range(1, 3);
      else if (r < 97) stall = $urandom_range(4, 10);
      else stall = $urandom_range(15, 40);
      run_len = $urandom_range(1, 20);
      m_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Queue one decoded byte with stuffing applied; an end byte may go raw (raw_end_pct)
  task automatic put_coded(logic [7:0] b);
    if (b == BYTE_END && $urandom_range(1, 100) > raw_end_pct) begin
      line_bytes.push_back(BYTE_ESC);
      line_bytes.push_back(BYTE_TEND);
    end else if (b == BYTE_ESC) begin
      line_bytes.push_back(BYTE_ESC);
      line_bytes.push_back(BYTE_TESC);
    end else begin
      line_bytes.push_back(b);
    end
  endtask

  // Queue a whole frame; payload comes from payload_bytes
  task automatic build_frame(bit with_addr, logic [6:0] addr, logic [7:0] cmd,
                             bit bad_crc);
    logic [7:0] crc;
    crc = crc8_update(CRC_START, BYTE_END);
    line_bytes.push_back(BYTE_END);
    if (with_addr) begin
      put_coded({1'b1, addr});
      crc = crc8_update(crc, {1'b0, addr});
    end else begin
      cmd[7] = 1'b0;
    end
    put_coded(cmd);
    crc = crc8_update(crc, cmd);
    put_coded(8'(payload_bytes.size()));
    crc = crc8_update(crc, 8'(payload_bytes.size()));
    foreach (payload_bytes[i]) begin
      put_coded(payload_bytes[i]);
      crc = crc8_update(crc, payload_bytes[i]);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    put_coded(crc);
    payload_bytes.delete();
  endtask

  // Drive queued line bytes, one transaction each
  task automatic send_line();
    int gap;
    while (line_bytes.size() > 0) begin
      gap = pick_gap();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= line_bytes.pop_front();
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      sent_count++;
    end
  endtask

  initial begin
    int r;
    int n;
    logic [7:0] b;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: junk in idle, escape byte in idle
    line_bytes = '{8'h00, 8'hFF, BYTE_ESC};
    send_line();
    // Command only, zero length
    build_frame(1'b0, 7'd0, 8'h05, 1'b0);
    send_line();
    // Top address and command, escaped end and escape bytes in payload
    payload_bytes = '{BYTE_END, BYTE_ESC};
    build_frame(1'b1, 7'h7F, 8'hFF, 1'b0);
    send_line();
    // Raw end byte as data, wrong CRC
    raw_end_pct = 100;
    payload_bytes = '{BYTE_END};
    build_frame(1'b0, 7'd0, 8'h10, 1'b1);
    raw_end_pct = 0;
    send_line();
    // Bad escape right after the frame start
    line_bytes = '{BYTE_END, BYTE_ESC, 8'h00};
    send_line();

    // Random traffic
    while (sent_count < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0);
      raw_end_pct = ($urandom_range(0, 9) == 0) ? 50 : 0;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // line noise
        n = $urandom_range(1, 4);
        repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 16) begin
        // frame broken by a bad escape
        line_bytes.push_back(BYTE_END);
        n = $urandom_range(0, 3);
        repeat (n) put_coded(8'($urandom_range(0, 255)));
        line_bytes.push_back(BYTE_ESC);
        do b = 8'($urandom_range(0, 255)); while (b == BYTE_TEND || b == BYTE_TESC);
        line_bytes.push_back(b);
      end else begin
        // well-formed frame with random content
        if ($urandom_range(0, 99) < 3) n = $urandom_range(100, 255);
        else n = $urandom_range(0, 8);
        repeat (n) begin
          case ($urandom_range(0, 19))
            0: payload_bytes.push_back(BYTE_END);
            1: payload_bytes.push_back(BYTE_ESC);
            default: payload_bytes.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        build_frame(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                    8'($urandom_range(0, 255)), $urandom_range(0, 99) < 15);
      end
      send_line();
    end
    s_tvalid <= 1'b0;

    // Let the monitor take the last transaction, drain, then a short settle
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.outstanding() != 0) sb.report("results left over", 64'(sb.outstanding()), 64'd0);

    if (sb.error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
